// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the port checker.
// Each takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte-range lock table package
// Transaction types, codes and range helpers for the lock table.
// ----------------------------------------------------------------------------
package brl_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 16;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TEST = 1'b1;

    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_UNLOCK = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BLOCK    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [1:0]  lock_kind;
        logic [63:0] range_start;
        logic [63:0] range_length;
        logic [31:0] session_id;
        logic [31:0] owner_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] hit_start;
        logic [63:0] hit_length;
        logic        hit_write;
        logic [31:0] hit_session;
        logic [31:0] hit_owner;
    } t_rsp;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] length;
        logic        write;
        logic [31:0] session;
        logic [31:0] owner;
    } t_entry;

    // End of (s, len) at or below b; the end is 65 bits wide, zero length runs to EOF.
    function automatic logic f_end_le(input logic [63:0] s, input logic [63:0] len,
                                      input logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, s} + {1'b0, len};
        if (len == 64'd0) return &b;
        return sum <= {1'b0, b};
    endfunction

    function automatic t_rsp f_rsp(input logic [1:0] status);
        t_rsp rsp;
        rsp = '0;
        rsp.status = status;
        return rsp;
    endfunction

    function automatic t_rsp f_hit(input t_entry ent);
        t_rsp rsp;
        rsp.status      = ST_OK;
        rsp.hit_start   = ent.start;
        rsp.hit_length  = ent.length;
        rsp.hit_write   = ent.write;
        rsp.hit_session = ent.session;
        rsp.hit_owner   = ent.owner;
        return rsp;
    endfunction

endpackage

// ===== rtl/brl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module brl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/byte_range_lock_table_unit.sv =====
// ----------------------------------------------------------------------------
// Byte-range lock table
// Ordered table of byte-range locks for one file: set, unlock and test.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake                   | Payload
// in      | input     | i_in_valid / o_in_ready     | i_in_data  (brl_pkg::t_req)
// out     | output    | o_out_valid / i_out_ready   | o_out_data (brl_pkg::t_rsp)
//
// One request at a time. The stored locks are scanned one per cycle through the
// RAM read port; an unlock moves the entries above the removed one down, one per
// cycle, in place of the rest of the scan. Reset empties the table at once.
// A stalled output holds its result; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module byte_range_lock_table_unit #(
    parameter int TABLE_DEPTH = brl_pkg::TABLE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  brl_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output brl_pkg::t_rsp o_out_data
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_FIN} t_state;

    t_state          r_state;
    brl_pkg::t_req   r_req;
    logic [64:0]     r_req_end;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_rd_idx;
    logic            r_chk_vld;
    logic [IDX_W-1:0] r_chk_idx;
    logic [IDX_W-1:0] r_wr_idx;
    brl_pkg::t_rsp   r_rsp;
    logic            r_out_vld;
    brl_pkg::t_rsp   r_out;

    logic            rd_en;
    logic            ram_we;
    logic [IDX_W-1:0] ram_waddr;
    brl_pkg::t_entry ram_wdata;
    logic [$bits(brl_pkg::t_entry)-1:0] ram_rdata;
    brl_pkg::t_entry ent;
    brl_pkg::t_entry new_ent;
    logic            req_le;
    logic            overlap;
    logic            conflict;
    logic            same;
    logic            is_unlock;
    logic            hit;
    logic            append;
    logic            shift_wr;
    logic            in_acc;
    logic            out_load;

    assign in_acc    = i_in_valid && o_in_ready;
    assign is_unlock = (r_req.operation == brl_pkg::OP_SET) &&
                       (r_req.lock_kind == brl_pkg::KIND_UNLOCK);
    assign out_load  = (r_state == S_FIN) && (!r_out_vld || i_out_ready);

    always_comb begin
        ent     = brl_pkg::t_entry'(ram_rdata);
        rd_en   = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_rd_idx < r_count);
        // request end is precomputed at accept
        req_le  = (r_req.range_length == 64'd0) ? (&ent.start)
                                               : (r_req_end <= {1'b0, ent.start});
        overlap = !(req_le || brl_pkg::f_end_le(ent.start, ent.length, r_req.range_start));
        conflict = overlap && ((r_req.lock_kind == brl_pkg::KIND_WRITE) || ent.write);
        same    = (ent.session == r_req.session_id) && (ent.owner == r_req.owner_id) &&
                  (ent.start == r_req.range_start) && (ent.length == r_req.range_length);
        hit     = r_chk_vld && (is_unlock ? same : conflict);
        append  = (r_state == S_SCAN) && !hit && !rd_en &&
                  (r_req.operation == brl_pkg::OP_SET) && !is_unlock &&
                  (r_count < DEPTH_CNT);
        shift_wr = (r_state == S_SHIFT) && r_chk_vld;

        new_ent.start   = r_req.range_start;
        new_ent.length  = r_req.range_length;
        new_ent.write   = (r_req.lock_kind == brl_pkg::KIND_WRITE);
        new_ent.session = r_req.session_id;
        new_ent.owner   = r_req.owner_id;

        ram_we    = append || shift_wr;
        ram_waddr = append ? r_count[IDX_W-1:0] : r_wr_idx;
        ram_wdata = append ? new_ent : ent;
    end

    brl_ram #(
        .WIDTH ($bits(brl_pkg::t_entry)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            // read pipeline: data for r_chk_idx shows up in the cycle after the read
            r_chk_vld <= rd_en;
            if (rd_en) begin
                r_chk_idx <= r_rd_idx[IDX_W-1:0];
                r_rd_idx  <= r_rd_idx + CNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req     <= i_in_data;
                        r_req_end <= {1'b0, i_in_data.range_start} +
                                     {1'b0, i_in_data.range_length};
                        r_rd_idx  <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        if (is_unlock) begin
                            r_wr_idx <= r_chk_idx;
                            r_state  <= S_SHIFT;
                        end else begin
                            r_rsp   <= (r_req.operation == brl_pkg::OP_TEST) ?
                                       brl_pkg::f_hit(ent) : brl_pkg::f_rsp(brl_pkg::ST_BLOCK);
                            r_state <= S_FIN;
                        end
                    end else if (!rd_en) begin
                        if (r_req.operation == brl_pkg::OP_TEST || is_unlock) begin
                            r_rsp <= brl_pkg::f_rsp(brl_pkg::ST_NOTFOUND);
                        end else if (append) begin
                            r_rsp   <= brl_pkg::f_rsp(brl_pkg::ST_OK);
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_rsp <= brl_pkg::f_rsp(brl_pkg::ST_FULL);
                        end
                        r_state <= S_FIN;
                    end
                end
                S_SHIFT: begin
                    if (shift_wr) begin
                        r_wr_idx <= r_wr_idx + IDX_W'(1);
                    end
                    if (!rd_en) begin
                        r_count <= r_count - CNT_W'(1);
                        r_rsp   <= brl_pkg::f_rsp(brl_pkg::ST_OK);
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out   <= r_rsp;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/brl_checker.sv =====
// ----------------------------------------------------------------------------
// Byte-range lock table port checker
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brl_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input brl_pkg::t_req i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input brl_pkg::t_rsp o_out_data
);

    logic in_acc;
    logic out_stall;
    logic no_hit;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign no_hit    = (o_out_data.hit_start == 64'd0) && (o_out_data.hit_length == 64'd0) &&
                       !o_out_data.hit_write && (o_out_data.hit_session == 32'd0) &&
                       (o_out_data.hit_owner == 32'd0);

    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid)
    `ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(o_out_data))
    // a request is worked on alone: no new transaction the cycle after one is taken
    `ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, in_acc, !o_in_ready)
    // hit fields are only filled on a successful test
    `ASSERT_IMP(a_hit_zero, i_clk, i_rst_n,
                o_out_valid && (o_out_data.status != brl_pkg::ST_OK), no_hit)

endmodule

bind byte_range_lock_table_unit brl_checker u_brl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
